### rtl/olst_pkg.sv
package olst_pkg;

	// list geometry
	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;
	localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [PTR_W-1:0]             ptr_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// operation codes
	localparam logic [2:0] OP_INS_FRONT  = 3'd0;
	localparam logic [2:0] OP_INS_BACK   = 3'd1;
	localparam logic [2:0] OP_INS_SORTED = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT  = 3'd3;
	localparam logic [2:0] OP_DEL_BACK   = 3'd4;
	localparam logic [2:0] OP_SEARCH     = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// ring index plus offset, modulo capacity
	function automatic ptr_t ptr_add(input ptr_t base, input ptr_t ofs);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= (PTR_W+1)'(CAPACITY))
			sum = sum - (PTR_W+1)'(CAPACITY);
		return sum[PTR_W-1:0];
	endfunction

	// ring index minus one, modulo capacity
	function automatic ptr_t ptr_dec(input ptr_t base);
		if (base == '0)
			return PTR_W'(CAPACITY - 1);
		return base - PTR_W'(1);
	endfunction

endpackage

### rtl/olst_ram.sv
module olst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

### rtl/ordered_list_engine_core.sv
// end inserts, deletes, full inserts and unknown codes go from accept through exec to done, then load the result
// search: a scan in list order up to the first match or the end of the list, then done
// sorted insert: a scan to the slot, then a shift of the tail one place back, then the place
// one item at a time: the next accept comes in the cycle after the result is loaded; a stalled
// result holds the sequencer; the walks use the single read and write port of the list ram
// reset: arst_n clears the count, ring head and handshake state at once; list ram is not cleared
module ordered_list_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // operation[2:0], item_value[34:3], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], found_position[8:2], entry_count[15:9]
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PLACE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]           state_q;
	logic [2:0]           op_q;
	olst_pkg::value_t     val_q;
	olst_pkg::ptr_t       head_q;
	olst_pkg::cnt_t       count_q;
	olst_pkg::cnt_t       iss_q;
	logic                 pend_q;
	olst_pkg::ptr_t       cmp_off_q;
	olst_pkg::cnt_t       pos_q;
	olst_pkg::ptr_t       j_q;
	olst_pkg::cnt_t       n_q;
	olst_pkg::ptr_t       wofs_q;
	logic [1:0]           res_status_q;
	logic [6:0]           res_pos_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [6:0]           out_pos_q;
	logic [6:0]           out_count_q;

	logic                 full;
	logic                 empty;
	logic                 cmp_hit;
	logic                 scan_issue;
	logic                 shift_issue;
	logic                 scan_end;
	olst_pkg::cnt_t       slot;
	logic                 ram_wr_en;
	olst_pkg::ptr_t       ram_wr_addr;
	olst_pkg::value_t     ram_wr_data;
	logic                 ram_rd_en;
	olst_pkg::ptr_t       ram_rd_addr;
	olst_pkg::value_t     rd_data;

	olst_ram #(
		.WIDTH (olst_pkg::VALUE_BITS),
		.DEPTH (olst_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (rd_data)
	);

	// shared compare and ram port control
	always_comb begin
		full  = (count_q == olst_pkg::cnt_t'(olst_pkg::CAPACITY));
		empty = (count_q == '0);
		if (op_q == olst_pkg::OP_SEARCH)
			cmp_hit = pend_q && (rd_data == val_q);
		else
			cmp_hit = pend_q && (rd_data >= val_q);
		scan_issue  = (state_q == S_SCAN) && !cmp_hit && (iss_q < count_q);
		shift_issue = (state_q == S_SHIFT) && (n_q != '0);
		scan_end    = cmp_hit || (!pend_q && (iss_q == count_q));
		slot        = cmp_hit ? olst_pkg::cnt_t'(cmp_off_q) : count_q;

		ram_rd_en   = scan_issue || shift_issue;
		if (state_q == S_SCAN)
			ram_rd_addr = olst_pkg::ptr_add(head_q, iss_q[olst_pkg::PTR_W-1:0]);
		else
			ram_rd_addr = olst_pkg::ptr_add(head_q, j_q);

		ram_wr_en   = 1'b0;
		ram_wr_addr = head_q;
		ram_wr_data = val_q;
		if (state_q == S_EXEC && !full && op_q == olst_pkg::OP_INS_FRONT) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = olst_pkg::ptr_dec(head_q);
		end else if (state_q == S_EXEC && !full && op_q == olst_pkg::OP_INS_BACK) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = olst_pkg::ptr_add(head_q, count_q[olst_pkg::PTR_W-1:0]);
		end else if (state_q == S_SHIFT && pend_q) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = olst_pkg::ptr_add(head_q, wofs_q);
			ram_wr_data = rd_data;
		end else if (state_q == S_PLACE) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = olst_pkg::ptr_add(head_q, pos_q[olst_pkg::PTR_W-1:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load on done, clear once taken
			if (state_q == S_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[2:0];
						val_q   <= olst_pkg::value_t'($signed(s_tdata[34:3]));
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_pos_q <= '0;
					iss_q     <= '0;
					pend_q    <= 1'b0;
					if ((op_q == olst_pkg::OP_INS_SORTED && !full) ||
							op_q == olst_pkg::OP_SEARCH)
						state_q <= S_SCAN;
					else
						state_q <= S_DONE;
					unique case (op_q)
						olst_pkg::OP_INS_FRONT: begin
							if (full) begin
								res_status_q <= olst_pkg::ST_FULL;
							end else begin
								res_status_q <= olst_pkg::ST_OK;
								head_q       <= olst_pkg::ptr_dec(head_q);
								count_q      <= count_q + 1'b1;
							end
						end
						olst_pkg::OP_INS_BACK: begin
							if (full) begin
								res_status_q <= olst_pkg::ST_FULL;
							end else begin
								res_status_q <= olst_pkg::ST_OK;
								count_q      <= count_q + 1'b1;
							end
						end
						olst_pkg::OP_INS_SORTED: begin
							if (full)
								res_status_q <= olst_pkg::ST_FULL;
							else
								res_status_q <= olst_pkg::ST_OK;
						end
						olst_pkg::OP_DEL_FRONT: begin
							if (empty) begin
								res_status_q <= olst_pkg::ST_EMPTY;
							end else begin
								res_status_q <= olst_pkg::ST_OK;
								head_q  <= olst_pkg::ptr_add(head_q, olst_pkg::ptr_t'(1));
								count_q <= count_q - 1'b1;
							end
						end
						olst_pkg::OP_DEL_BACK: begin
							if (empty) begin
								res_status_q <= olst_pkg::ST_EMPTY;
							end else begin
								res_status_q <= olst_pkg::ST_OK;
								count_q      <= count_q - 1'b1;
							end
						end
						default: begin
							res_status_q <= olst_pkg::ST_OK;
						end
					endcase
				end
				S_SCAN: begin
					// issue the next read while comparing the previous one
					if (scan_issue) begin
						iss_q     <= iss_q + 1'b1;
						pend_q    <= 1'b1;
						cmp_off_q <= iss_q[olst_pkg::PTR_W-1:0];
					end else begin
						pend_q <= 1'b0;
					end
					if (scan_end) begin
						if (op_q == olst_pkg::OP_SEARCH) begin
							state_q <= S_DONE;
							if (cmp_hit) begin
								res_status_q <= olst_pkg::ST_OK;
								res_pos_q    <= 7'(cmp_off_q) + 7'd1;
							end else begin
								res_status_q <= olst_pkg::ST_NOTFOUND;
							end
						end else begin
							pos_q   <= slot;
							j_q     <= olst_pkg::ptr_t'(count_q - 1'b1);
							n_q     <= count_q - slot;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					// move the tail one place back, last entry first
					if (shift_issue) begin
						j_q    <= j_q - 1'b1;
						n_q    <= n_q - 1'b1;
						wofs_q <= j_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (n_q == '0 && !pend_q)
						state_q <= S_PLACE;
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_status_q <= res_status_q;
						out_pos_q    <= res_pos_q;
						out_count_q  <= 7'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_pos_q, out_status_q};

endmodule

### rtl/olst_chk.sv
module olst_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] <= 7'(olst_pkg::CAPACITY))
		else $error("entry count above capacity");

	// full status only on a full list
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == olst_pkg::ST_FULL |->
			m_tdata[15:9] == 7'(olst_pkg::CAPACITY))
		else $error("full status with room left");

	// empty status only on an empty list
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == olst_pkg::ST_EMPTY |-> m_tdata[15:9] == 7'd0)
		else $error("empty status with entries left");

	// a found position is a valid place in the list
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8:2] != 7'd0 |->
			m_tdata[1:0] == olst_pkg::ST_OK && m_tdata[8:2] <= m_tdata[15:9])
		else $error("found position out of range");

endmodule

bind ordered_list_engine_core olst_chk u_chk (.*);
